// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the timestamp difference RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// ===== rtl/ctd_pkg.sv =====
// Types, constants and calendar helpers for the timestamp difference block.
`default_nettype none

package ctd_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_EARLIEST_YEAR = 2'd0;
   localparam logic [1:0] CSR_LATEST_YEAR   = 2'd1;

   localparam logic [13:0] EARLIEST_YEAR_RESET = 14'd1888;
   localparam logic [13:0] LATEST_YEAR_RESET   = 14'd2100;

   // One timestamp, narrowed to the ranges that a valid timestamp can hold.
   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
   } stamp_type;

   // Classified request passed from the front to the back.
   typedef struct packed {
      logic        first_valid;
      logic        second_valid;
      logic        same_moment;
      logic        goes_forward;
      stamp_type   later;
      stamp_type   earlier;
      logic [4:0]  prev_len;
   } work_type;

   // Days in a month, given whether the year is a leap year.
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      begin
         unique case (month)
            4'd2:                       len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
         endcase
         return len;
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/calendar_timestamp_difference.sv =====
// Calendar timestamp difference: top level joining front end, queue and back end.
//   A request carries two timestamps (day, month, year, hour, minute) on the
//   req_ ports and is taken at a rising edge with req_valid high and
//   req_stall low. Each request yields exactly one response on the rsp_
//   ports, taken at an edge with rsp_valid high and rsp_stall low: validity
//   of each timestamp, equality, order, and the year/month/day/hour/minute
//   difference (zero when either timestamp is invalid).
//   One request is accepted every cycle while req_stall is low. The front
//   end checks and orders the pair in the cycle of acceptance and writes it
//   to a two-entry queue; the back end runs the borrow chain from the queue
//   head into the response register.
//   When rsp_stall holds, the response stays put, the queue fills and then
//   req_stall rises until the response is taken.
//   The csr_ port writes the earliest (index 0) and latest (index 1) valid
//   year; csr_ready is always high. The user must make writes only while
//   idle; the block does not enforce this. Reset empties the queue and the
//   response register and restores the year limits to 1888 and 2100.
`default_nettype none

module calendar_timestamp_difference
   import ctd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [13:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [6:0]  req_first_day,
   input  wire logic [6:0]  req_first_month,
   input  wire logic [13:0] req_first_year,
   input  wire logic [6:0]  req_first_hour,
   input  wire logic [6:0]  req_first_minute,
   input  wire logic [6:0]  req_second_day,
   input  wire logic [6:0]  req_second_month,
   input  wire logic [13:0] req_second_year,
   input  wire logic [6:0]  req_second_hour,
   input  wire logic [6:0]  req_second_minute,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_first_valid,
   output logic             rsp_second_valid,
   output logic             rsp_same_moment,
   output logic             rsp_goes_forward,
   output logic [13:0]      rsp_diff_years,
   output logic [3:0]       rsp_diff_months,
   output logic [4:0]       rsp_diff_days,
   output logic [4:0]       rsp_diff_hours,
   output logic [5:0]       rsp_diff_minutes
);

   work_type front_work, head_work;
   logic     q_full, q_not_empty, q_pop, q_push;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // Checks, ordering and year limit registers.
   ctd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .first_day     (req_first_day),
      .first_month   (req_first_month),
      .first_year    (req_first_year),
      .first_hour    (req_first_hour),
      .first_minute  (req_first_minute),
      .second_day    (req_second_day),
      .second_month  (req_second_month),
      .second_year   (req_second_year),
      .second_hour   (req_second_hour),
      .second_minute (req_second_minute),
      .work          (front_work)
   );

   // Decoupling queue.
   ctd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_work),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (head_work)
   );

   // Borrow chain and response register.
   ctd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .work_valid       (q_not_empty),
      .work             (head_work),
      .work_pop         (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_first_valid  (rsp_first_valid),
      .rsp_second_valid (rsp_second_valid),
      .rsp_same_moment  (rsp_same_moment),
      .rsp_goes_forward (rsp_goes_forward),
      .rsp_diff_years   (rsp_diff_years),
      .rsp_diff_months  (rsp_diff_months),
      .rsp_diff_days    (rsp_diff_days),
      .rsp_diff_hours   (rsp_diff_hours),
      .rsp_diff_minutes (rsp_diff_minutes)
   );

endmodule

`default_nettype wire

// ===== rtl/ctd_front.sv =====
// Front end: year limit registers, timestamp checks, ordering and selection.
`default_nettype none

module ctd_front
   import ctd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [13:0] csr_data,
   input  wire logic [6:0]  first_day,
   input  wire logic [6:0]  first_month,
   input  wire logic [13:0] first_year,
   input  wire logic [6:0]  first_hour,
   input  wire logic [6:0]  first_minute,
   input  wire logic [6:0]  second_day,
   input  wire logic [6:0]  second_month,
   input  wire logic [13:0] second_year,
   input  wire logic [6:0]  second_hour,
   input  wire logic [6:0]  second_minute,
   output work_type         work
);

   logic [13:0] earliest_ff, earliest_in;
   logic [13:0] latest_ff, latest_in;
   logic [6:0]  hour_a, hour_b;
   logic        leap_a, leap_b, leap_hi;
   logic        ok_a, ok_b, fwd;
   logic [3:0]  hi_month, prev_month;

   // Leap rule: divisible by 4 but not by 100, or divisible by 400.
   // Divisibility by 25 uses a reciprocal multiply, exact for 14-bit years.
   function automatic logic is_leap(input logic [13:0] y);
      logic [26:0] prod;
      logic [9:0]  q;
      logic [14:0] back;
      logic        by25;
      begin
         prod = 27'(y) * 27'd5243;
         q    = prod[26:17];
         back = (15'(q) << 4) + (15'(q) << 3) + 15'(q);
         by25 = (back == {1'b0, y});
         return by25 ? (y[3:0] == 4'd0) : (y[1:0] == 2'd0);
      end
   endfunction

   // Full validity check of one timestamp.
   function automatic logic stamp_ok(input logic [6:0] d, input logic [6:0] m,
                                     input logic [13:0] y, input logic [6:0] h,
                                     input logic [6:0] mi, input logic lp,
                                     input logic [13:0] lo_y, input logic [13:0] hi_y);
      logic yr_ok, mo_ok, dy_ok;
      begin
         yr_ok = (y >= lo_y) && (y <= hi_y);
         mo_ok = (m >= 7'd1) && (m <= 7'd12);
         dy_ok = (d >= 7'd1) && (d <= {2'b00, month_len(m[3:0], lp)});
         return yr_ok && mo_ok && dy_ok && (h <= 7'd24) && (mi <= 7'd59);
      end
   endfunction

   // Year limit registers; the user must write them only while the block is idle, which is not enforced here.
   always_comb begin
      earliest_in = earliest_ff;
      latest_in   = latest_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_EARLIEST_YEAR: earliest_in = csr_data;
            CSR_LATEST_YEAR:   latest_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         earliest_ff <= EARLIEST_YEAR_RESET;
         latest_ff   <= LATEST_YEAR_RESET;
      end else begin
         earliest_ff <= earliest_in;
         latest_ff   <= latest_in;
      end
   end

   // Hour 24 reads as midnight.
   assign hour_a = (first_hour == 7'd24) ? 7'd0 : first_hour;
   assign hour_b = (second_hour == 7'd24) ? 7'd0 : second_hour;

   assign leap_a = is_leap(first_year);
   assign leap_b = is_leap(second_year);

   assign ok_a = stamp_ok(first_day, first_month, first_year, first_hour, first_minute,
                          leap_a, earliest_ff, latest_ff);
   assign ok_b = stamp_ok(second_day, second_month, second_year, second_hour,
                          second_minute, leap_b, earliest_ff, latest_ff);

   // The first timestamp is not later than the second.
   always_comb begin
      priority if (first_year != second_year)   fwd = first_year < second_year;
      else if (first_month != second_month)     fwd = first_month < second_month;
      else if (first_day != second_day)         fwd = first_day < second_day;
      else if (hour_a != hour_b)                fwd = hour_a < hour_b;
      else                                      fwd = first_minute <= second_minute;
   end

   // Length of the month before the later timestamp's month.
   assign hi_month   = fwd ? second_month[3:0] : first_month[3:0];
   assign leap_hi    = fwd ? leap_b : leap_a;
   assign prev_month = (hi_month == 4'd1) ? 4'd12 : hi_month - 4'd1;

   // Assemble the classified request.
   always_comb begin
      stamp_type sa, sb;
      sa = '{year: first_year, month: first_month[3:0], day: first_day[4:0],
             hour: hour_a[4:0], minute: first_minute[5:0]};
      sb = '{year: second_year, month: second_month[3:0], day: second_day[4:0],
             hour: hour_b[4:0], minute: second_minute[5:0]};
      work.first_valid  = ok_a;
      work.second_valid = ok_b;
      work.same_moment  = (first_year == second_year) && (first_month == second_month) &&
                          (first_day == second_day) && (hour_a == hour_b) &&
                          (first_minute == second_minute);
      work.goes_forward = fwd;
      work.later        = fwd ? sb : sa;
      work.earlier      = fwd ? sa : sb;
      work.prev_len     = month_len(prev_month, leap_hi);
   end

endmodule

`default_nettype wire

// ===== rtl/ctd_queue.sv =====
// Two-entry queue that decouples the front end from the borrow stage.
`default_nettype none

`include "assert_macros.svh"

module ctd_queue
   import ctd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire work_type push_data,
   output logic          full,
   input  wire logic     pop,
   output logic          not_empty,
   output work_type      head
);

   work_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_NEVER(a_no_overflow, clock, reset, push && full, "queue written while full")
   `ASSERT_NEVER(a_no_underflow, clock, reset, pop && !not_empty, "queue read while empty")

endmodule

`default_nettype wire

// ===== rtl/ctd_back.sv =====
// Back end: borrow chain for the difference and the result register.
`default_nettype none

`include "assert_macros.svh"

module ctd_back
   import ctd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         work_valid,
   input  wire work_type     work,
   output logic              work_pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic              rsp_first_valid,
   output logic              rsp_second_valid,
   output logic              rsp_same_moment,
   output logic              rsp_goes_forward,
   output logic [13:0]       rsp_diff_years,
   output logic [3:0]        rsp_diff_months,
   output logic [4:0]        rsp_diff_days,
   output logic [4:0]        rsp_diff_hours,
   output logic [5:0]        rsp_diff_minutes
);

   stamp_type          hi, lo;
   logic               both_ok;
   logic               min_borrow, hour_borrow, day_borrow, month_borrow;
   logic [5:0]         dmin;
   logic [5:0]         hour1;
   logic [4:0]         dhour;
   logic [5:0]         day1;
   logic signed [6:0]  day2;
   logic [4:0]         dday;
   logic [3:0]         mon1;
   logic [3:0]         dmon;
   logic [13:0]        dyear;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        first_valid_ff, second_valid_ff, same_ff, fwd_ff;
   logic [13:0] years_ff;
   logic [3:0]  months_ff;
   logic [4:0]  days_ff, hours_ff;
   logic [5:0]  minutes_ff;

   assign hi      = work.later;
   assign lo      = work.earlier;
   assign both_ok = work.first_valid && work.second_valid;

   // Minutes, borrowing an hour when needed.
   always_comb begin
      min_borrow = lo.minute > hi.minute;
      dmin       = hi.minute + (min_borrow ? 6'd60 : 6'd0) - lo.minute;
   end

   // Hours; a borrowed hour may take the later hour below zero.
   always_comb begin
      hour1       = {1'b0, hi.hour} - {5'd0, min_borrow};
      hour_borrow = hour1[5] || (lo.hour > hour1[4:0]);
      dhour       = hour1[4:0] + (hour_borrow ? 5'd24 : 5'd0) - lo.hour;
   end

   // Days, adding the previous month's length on a borrow, then the clamp.
   always_comb begin
      day1         = {1'b0, hi.day} - {5'd0, hour_borrow};
      day_borrow   = hour_borrow;
      month_borrow = {1'b0, lo.day} > day1;
      day2         = $signed({1'b0, day1}) +
                     $signed({2'b00, (month_borrow ? work.prev_len : 5'd0)}) -
                     $signed({2'b00, lo.day});
      if (month_borrow && (day2 <= 7'sd0)) begin
         dday = day_borrow ? 5'd0 : 5'd1;
      end else begin
         dday = day2[4:0];
      end
   end

   // Months and years.
   always_comb begin
      logic year_borrow;
      mon1        = hi.month - {3'd0, month_borrow};
      year_borrow = lo.month > mon1;
      dmon        = mon1 + (year_borrow ? 4'd12 : 4'd0) - lo.month;
      dyear       = hi.year - {13'd0, year_borrow} - lo.year;
   end

   // Take the next request whenever the result register is free or draining.
   assign work_pop     = work_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = work_pop || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload; differences are zero unless both timestamps are valid.
   always_ff @(posedge clock) begin
      if (work_pop) begin
         first_valid_ff  <= work.first_valid;
         second_valid_ff <= work.second_valid;
         same_ff         <= work.same_moment;
         fwd_ff          <= work.goes_forward;
         years_ff        <= both_ok ? dyear : 14'd0;
         months_ff       <= both_ok ? dmon : 4'd0;
         days_ff         <= both_ok ? dday : 5'd0;
         hours_ff        <= both_ok ? dhour : 5'd0;
         minutes_ff      <= both_ok ? dmin : 6'd0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_first_valid  = first_valid_ff;
   assign rsp_second_valid = second_valid_ff;
   assign rsp_same_moment  = same_ff;
   assign rsp_goes_forward = fwd_ff;
   assign rsp_diff_years   = years_ff;
   assign rsp_diff_months  = months_ff;
   assign rsp_diff_days    = days_ff;
   assign rsp_diff_hours   = hours_ff;
   assign rsp_diff_minutes = minutes_ff;

   `ASSERT_AT(a_invalid_zero, clock, reset,
      (rsp_valid && !(rsp_first_valid && rsp_second_valid)) |->
      (rsp_diff_years == 14'd0 && rsp_diff_months == 4'd0 && rsp_diff_days == 5'd0 &&
       rsp_diff_hours == 5'd0 && rsp_diff_minutes == 6'd0),
      "nonzero difference for an invalid timestamp")
   `ASSERT_AT(a_same_forward, clock, reset,
      (rsp_valid && rsp_same_moment) |-> rsp_goes_forward,
      "equal timestamps not reported as in order")

endmodule

`default_nettype wire
